// ===== rtl/peu_pkg.sv =====
// Shared types, codes and fixed-point helpers of the particle Euler integrator.
// Used by peu_ctrl, peu_datapath and particle_euler_integrator_top.
package peu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int S_TDATA_W  = 96;    // three 32-bit vector components
    localparam int S_TUSER_W  = 3;     // operation
    localparam int M_TDATA_W  = 200;   // 6 x 32 bits + flag, padded to bytes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;

    // operation codes
    localparam logic [2:0] OP_ADD_FORCE = 3'd0;
    localparam logic [2:0] OP_FORCE_ACC = 3'd1;
    localparam logic [2:0] OP_STEP      = 3'd2;
    localparam logic [2:0] OP_CLR_FORCE = 3'd3;
    localparam logic [2:0] OP_LOAD_POS  = 3'd4;
    localparam logic [2:0] OP_LOAD_VEL  = 3'd5;

    // integration modes (the unused code steps as explicit)
    localparam logic [1:0] MODE_EXPLICIT = 2'd0;
    localparam logic [1:0] MODE_SEMI     = 2'd1;
    localparam logic [1:0] MODE_KINEMAT  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd3;

    localparam logic [30:0] DT_RESET     = 31'd1092;
    localparam logic [62:0] THRESH_RESET = 63'd4295;

    // multiplier operand selects
    localparam logic [1:0] MA_VEL   = 2'd0;
    localparam logic [1:0] MA_ACC   = 2'd1;
    localparam logic [1:0] MA_TMP   = 2'd2;
    localparam logic [1:0] MA_FORCE = 2'd3;

    localparam logic [1:0] MB_DT    = 2'd0;
    localparam logic [1:0] MB_DTH   = 2'd1;
    localparam logic [1:0] MB_INVM  = 2'd2;
    localparam logic [1:0] MB_VEL   = 2'd3;

    // state register updates
    localparam logic [1:0] UPD_HOLD = 2'd0;
    localparam logic [1:0] UPD_LOAD = 2'd1;   // take the captured vector
    localparam logic [1:0] UPD_ADD  = 2'd2;   // add scaled product (pos/vel) or vector (force)
    localparam logic [1:0] UPD_CLR  = 2'd3;   // force only

    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [1:0] mul_a_sel;
        logic [1:0] mul_b_sel;
        logic [1:0] pos_op;
        logic [1:0] vel_op;
        logic [1:0] frc_op;
        logic       tmp_en;
        logic       acc_en;
        logic       sum_en;
        logic       out_load;
    } t_dp_cmd;

    function automatic logic signed [WORD_W-1:0] f_sat32(input logic signed [64:0] v);
        logic signed [WORD_W-1:0] r;
        if (!v[64] && (|v[63:31])) begin
            r = SAT_MAX;
        end else if (v[64] && !(&v[63:31])) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] f_sadd(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return f_sat32(s);
    endfunction

    // product back to word: floor shift, then saturate
    function automatic logic signed [WORD_W-1:0] f_fin(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        return f_sat32(65'(s));
    endfunction

endpackage

// ===== rtl/peu_ctrl.sv =====
// Sequencer of the particle Euler integrator: input/output handshake and
// per-cycle datapath commands. Depends on peu_pkg.
module peu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [2:0]          i_op,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic [1:0]          i_mode,
    output peu_pkg::t_dp_cmd    o_cmd
);
    import peu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_X1   = 3'd1;
    localparam logic [2:0] S_X2   = 3'd2;
    localparam logic [2:0] S_X3   = 3'd3;
    localparam logic [2:0] S_X4   = 3'd4;
    localparam logic [2:0] S_SQ   = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic       r_m_valid, n_m_valid;
    logic       w_accept;
    t_dp_cmd    w_cmd;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_cmd      = w_cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.capture = 1'b1;
                    n_op          = i_op;
                    n_state       = S_X1;
                end
            end
            S_X1: begin
                n_state = S_SQ;
                priority case (r_op)
                    OP_ADD_FORCE: w_cmd.frc_op = UPD_ADD;
                    OP_CLR_FORCE: w_cmd.frc_op = UPD_CLR;
                    OP_LOAD_POS:  w_cmd.pos_op = UPD_LOAD;
                    OP_LOAD_VEL:  w_cmd.vel_op = UPD_LOAD;
                    OP_FORCE_ACC: begin
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.mul_a_sel = MA_FORCE;
                        w_cmd.mul_b_sel = MB_INVM;
                        n_state         = S_X2;
                    end
                    OP_STEP: begin
                        w_cmd.mul_en = 1'b1;
                        n_state      = S_X2;
                        priority case (i_mode)
                            MODE_SEMI: begin
                                w_cmd.mul_a_sel = MA_ACC;
                                w_cmd.mul_b_sel = MB_DT;
                            end
                            MODE_KINEMAT: begin
                                w_cmd.mul_a_sel = MA_ACC;
                                w_cmd.mul_b_sel = MB_DTH;
                            end
                            default: begin
                                w_cmd.mul_a_sel = MA_VEL;
                                w_cmd.mul_b_sel = MB_DT;
                            end
                        endcase
                    end
                    default: ;  // unused codes leave the state alone
                endcase
            end
            S_X2: begin
                if (r_op == OP_FORCE_ACC) begin
                    w_cmd.acc_en = 1'b1;
                    n_state      = S_SQ;
                end else begin
                    n_state = S_X3;
                    priority case (i_mode)
                        MODE_SEMI: w_cmd.vel_op = UPD_ADD;
                        MODE_KINEMAT: begin
                            w_cmd.tmp_en    = 1'b1;
                            w_cmd.mul_en    = 1'b1;
                            w_cmd.mul_a_sel = MA_ACC;
                            w_cmd.mul_b_sel = MB_DT;
                        end
                        default: begin
                            w_cmd.pos_op    = UPD_ADD;
                            w_cmd.mul_en    = 1'b1;
                            w_cmd.mul_a_sel = MA_ACC;
                            w_cmd.mul_b_sel = MB_DT;
                        end
                    endcase
                end
            end
            S_X3: begin
                n_state = S_X4;
                priority case (i_mode)
                    MODE_SEMI: begin
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.mul_a_sel = MA_VEL;
                        w_cmd.mul_b_sel = MB_DT;
                    end
                    MODE_KINEMAT: begin
                        w_cmd.vel_op    = UPD_ADD;
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.mul_a_sel = MA_TMP;
                        w_cmd.mul_b_sel = MB_DT;
                    end
                    default: begin
                        w_cmd.vel_op = UPD_ADD;
                        n_state      = S_SQ;
                    end
                endcase
            end
            S_X4: begin
                w_cmd.pos_op = UPD_ADD;
                n_state      = S_SQ;
            end
            S_SQ: begin
                w_cmd.mul_en    = 1'b1;
                w_cmd.mul_a_sel = MA_VEL;
                w_cmd.mul_b_sel = MB_VEL;
                n_state         = S_SUM;
            end
            S_SUM: begin
                w_cmd.sum_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_ADD_FORCE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_m_valid <= n_m_valid;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_X1))
        else $error("accepted word did not start the sequence");

    a_out_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_m_valid && !i_m_tready) |=> (r_state == S_OUT))
        else $error("result stage left while output register full");

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> r_m_valid)
        else $error("loaded result not marked valid");

    a_one_state_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.pos_op != UPD_HOLD, w_cmd.vel_op != UPD_HOLD,
                  w_cmd.frc_op != UPD_HOLD, w_cmd.acc_en}))
        else $error("two state vectors written in one cycle");

endmodule

// ===== rtl/peu_datapath.sv =====
// Datapath of the particle Euler integrator: per-axis state, one multiplier
// per axis, squared-speed sum and output register. Depends on peu_pkg.
module peu_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  peu_pkg::t_dp_cmd                  i_cmd,
    input  logic [peu_pkg::S_TDATA_W-1:0]     i_vec,
    input  logic [30:0]                       i_dt,
    input  logic [30:0]                       i_invm,
    input  logic [62:0]                       i_thresh,
    output logic [peu_pkg::M_TDATA_W-1:0]     o_tdata
);
    import peu_pkg::*;

    logic [S_TDATA_W-1:0]     r_vec;
    logic signed [63:0]       r_prod [3];
    logic signed [WORD_W-1:0] r_out_pos [3];
    logic signed [WORD_W-1:0] r_out_vel [3];
    logic [63:0]              r_speed2;
    logic                     r_moving;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vec <= i_vec;
        end
        if (i_cmd.sum_en) begin
            r_speed2 <= $unsigned(r_prod[0]) + $unsigned(r_prod[1]) + $unsigned(r_prod[2]);
        end
        if (i_cmd.out_load) begin
            r_moving <= (r_speed2 > {1'b0, i_thresh});
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [WORD_W-1:0] r_pos, r_vel, r_acc, r_frc, r_tmp;
        logic signed [WORD_W-1:0] w_in, w_fin, w_pos_add, w_vel_add;
        logic signed [32:0]       w_ma, w_mb;
        logic signed [65:0]       w_mul;

        assign w_in      = r_vec[WORD_W*k +: WORD_W];
        assign w_fin     = f_fin(r_prod[k]);
        assign w_pos_add = f_sadd(r_pos, w_fin);
        assign w_vel_add = f_sadd(r_vel, w_fin);
        assign w_mul     = w_ma * w_mb;

        always_comb begin
            unique case (i_cmd.mul_a_sel)
                MA_VEL:   w_ma = 33'(r_vel);
                MA_ACC:   w_ma = 33'(r_acc);
                MA_TMP:   w_ma = 33'(r_tmp);
                MA_FORCE: w_ma = 33'(r_frc);
            endcase
            unique case (i_cmd.mul_b_sel)
                MB_DT:   w_mb = {2'b00, i_dt};
                MB_DTH:  w_mb = {3'b000, i_dt[30:1]};
                MB_INVM: w_mb = {2'b00, i_invm};
                MB_VEL:  w_mb = 33'(r_vel);
            endcase
        end

        // payload and scratch
        always_ff @(posedge i_clk) begin
            if (i_cmd.mul_en) begin
                r_prod[k] <= w_mul[63:0];   // |product| <= 2^62
            end
            if (i_cmd.tmp_en) begin
                r_tmp <= w_vel_add;
            end
            if (i_cmd.out_load) begin
                r_out_pos[k] <= r_pos;
                r_out_vel[k] <= r_vel;
            end
        end

        // architectural state
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos <= '0;
                r_vel <= '0;
                r_acc <= '0;
                r_frc <= '0;
            end else begin
                priority case (i_cmd.pos_op)
                    UPD_LOAD: r_pos <= w_in;
                    UPD_ADD:  r_pos <= w_pos_add;
                    default:  ;
                endcase
                priority case (i_cmd.vel_op)
                    UPD_LOAD: r_vel <= w_in;
                    UPD_ADD:  r_vel <= w_vel_add;
                    default:  ;
                endcase
                priority case (i_cmd.frc_op)
                    UPD_ADD:  r_frc <= f_sadd(r_frc, w_in);
                    UPD_CLR:  r_frc <= '0;
                    default:  ;
                endcase
                if (i_cmd.acc_en) begin
                    r_acc <= w_fin;
                end
            end
        end
    end

    assign o_tdata = {7'b0, r_moving,
                      r_out_vel[2], r_out_vel[1], r_out_vel[0],
                      r_out_pos[2], r_out_pos[1], r_out_pos[0]};

endmodule

// ===== rtl/particle_euler_integrator_top.sv =====
// Top level of the particle Euler integrator: configuration registers and
// the sequencer/datapath pair. Depends on peu_pkg, peu_ctrl, peu_datapath.
// Slave channel: one word per command; tuser carries the operation (add
//   force, force to acceleration, step, clear force, load position, load
//   velocity), tdata the Q16.16 vector x, y, z for the commands that use it.
// Master channel: one word per command with the position and velocity
//   after the command and the moving flag (squared speed above threshold).
// Config port: plain writes of mode, dt, inverse mass and threshold; the user
//   writes only while no command is in flight, the block does not enforce it.
// Sequencing: force to acceleration takes more sequencer states than
//   force, clear, load and spare commands, an explicit step more still and
//   semi-implicit and kinematic steps the most, set by the single
//   multiplier per axis, reused for every product and then the squared
//   speed. One command at a time; a new word can be taken the cycle after
//   the previous result is loaded into the output register.
// Reset: state vectors clear to zero, registers take their defaults, the
//   output is empty. When the receiver stalls, the result waits in the
//   output register and a following command holds in its result stage.
module particle_euler_integrator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [peu_pkg::S_TDATA_W-1:0]      i_s_tdata,   // [31:0] x, [63:32] y, [95:64] z
    input  logic [peu_pkg::S_TUSER_W-1:0]      i_s_tuser,   // [2:0] operation
    // master
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] pos x, [63:32] pos y, [95:64] pos z, [127:96] vel x,
    // [159:128] vel y, [191:160] vel z, [192] is_moving, rest zero
    output logic [peu_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [peu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [peu_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import peu_pkg::*;

    logic [1:0]  r_mode;
    logic [30:0] r_dt;
    logic [30:0] r_invm;
    logic [62:0] r_thresh;
    t_dp_cmd     w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_EXPLICIT;
            r_dt     <= DT_RESET;
            r_invm   <= '0;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_DT:     r_dt     <= i_cfg_data[30:0];
                CFG_INVM:   r_invm   <= i_cfg_data[30:0];
                CFG_THRESH: r_thresh <= i_cfg_data[62:0];
            endcase
        end
    end

    peu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_mode     (r_mode),
        .o_cmd      (w_cmd)
    );

    peu_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_vec    (i_s_tdata),
        .i_dt     (r_dt),
        .i_invm   (r_invm),
        .i_thresh (r_thresh),
        .o_tdata  (o_m_tdata)
    );

endmodule

// ===== tb/peu_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the particle Euler integrator: mirrors the registers and the
// particle state, predicts every result word and compares it. Uses peu_pkg.
module peu_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [peu_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [31:0] x, [63:32] y, [95:64] z
    input  logic [peu_pkg::S_TUSER_W-1:0]  i_s_tuser,   // [2:0] operation
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [95:0] pos x/y/z, [191:96] vel x/y/z, [192] is_moving
    input  logic [peu_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [peu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [peu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import peu_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic             moving;
    } t_particle_word;

    localparam longint WORD_TOP    = 64'sd2147483647;
    localparam longint WORD_BOTTOM = -64'sd2147483648;

    logic [1:0]         mode_q;
    logic [30:0]        dt_q;
    logic [30:0]        invm_q;
    logic [62:0]        thr_q;
    logic signed [31:0] pos_q [3];
    logic signed [31:0] vel_q [3];
    logic signed [31:0] acc_q [3];
    logic signed [31:0] frc_q [3];

    t_particle_word expected_states [$];
    int             n_fail = 0;

    assign o_fail_count = n_fail;

    function automatic logic signed [31:0] clamp_word(input longint v);
        if (v > WORD_TOP) begin
            return 32'(WORD_TOP);
        end
        if (v < WORD_BOTTOM) begin
            return 32'(WORD_BOTTOM);
        end
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return clamp_word(longint'(a) + longint'(b));
    endfunction

    // exact product, floor shift back to Q16.16, saturate
    function automatic logic signed [31:0] scale(input logic signed [31:0] a,
                                                 input logic [30:0] b);
        longint prod;
        prod = longint'(a) * longint'({1'b0, b});
        return clamp_word(prod >>> FRAC_BITS);
    endfunction

    function automatic void step_component(input int k);
        logic signed [31:0] v0;
        logic signed [31:0] a;
        logic signed [31:0] v1;
        v0 = vel_q[k];
        a  = acc_q[k];
        case (mode_q)
            MODE_SEMI: begin
                v1       = add_sat(v0, scale(a, dt_q));
                vel_q[k] = v1;
                pos_q[k] = add_sat(pos_q[k], scale(v1, dt_q));
            end
            MODE_KINEMAT: begin
                v1       = add_sat(v0, scale(a, dt_q >> 1));
                pos_q[k] = add_sat(pos_q[k], scale(v1, dt_q));
                vel_q[k] = add_sat(v0, scale(a, dt_q));
            end
            default: begin   // explicit, and the spare mode code
                pos_q[k] = add_sat(pos_q[k], scale(v0, dt_q));
                vel_q[k] = add_sat(v0, scale(a, dt_q));
            end
        endcase
    endfunction

    function automatic t_particle_word advance_particle(input logic [2:0] op,
                                                        input logic [95:0] vec);
        t_particle_word r;
        logic [63:0]    speed_sq;
        longint         sq;
        int             k;
        for (k = 0; k < 3; k++) begin
            case (op)
                OP_ADD_FORCE: frc_q[k] = add_sat(frc_q[k], vec[32*k +: 32]);
                OP_FORCE_ACC: acc_q[k] = scale(frc_q[k], invm_q);
                OP_STEP:      step_component(k);
                OP_CLR_FORCE: frc_q[k] = '0;
                OP_LOAD_POS:  pos_q[k] = vec[32*k +: 32];
                OP_LOAD_VEL:  vel_q[k] = vec[32*k +: 32];
                default: ;    // spare codes leave the state alone
            endcase
        end
        speed_sq = '0;
        for (k = 0; k < 3; k++) begin
            sq       = longint'(vel_q[k]) * longint'(vel_q[k]);
            speed_sq = speed_sq + 64'(sq);
            r.pos[k] = pos_q[k];
            r.vel[k] = vel_q[k];
        end
        r.moving = (speed_sq > {1'b0, thr_q});
        return r;
    endfunction

    task automatic compare_word(input t_particle_word want, input t_particle_word got);
        int k;
        for (k = 0; k < 3; k++) begin
            if (got.pos[k] !== want.pos[k]) begin
                n_fail++;
                $display("%0t: position[%0d] expected %h, got %h",
                         $time, k, want.pos[k], got.pos[k]);
            end
            if (got.vel[k] !== want.vel[k]) begin
                n_fail++;
                $display("%0t: velocity[%0d] expected %h, got %h",
                         $time, k, want.vel[k], got.vel[k]);
            end
        end
        if (got.moving !== want.moving) begin
            n_fail++;
            $display("%0t: is_moving expected %b, got %b", $time, want.moving, got.moving);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q = MODE_EXPLICIT;
            dt_q   = DT_RESET;
            invm_q = '0;
            thr_q  = THRESH_RESET;
            for (int k = 0; k < 3; k++) begin
                pos_q[k] = '0;
                vel_q[k] = '0;
                acc_q[k] = '0;
                frc_q[k] = '0;
            end
            expected_states.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:   mode_q = i_cfg_data[1:0];
                    CFG_DT:     dt_q   = i_cfg_data[30:0];
                    CFG_INVM:   invm_q = i_cfg_data[30:0];
                    CFG_THRESH: thr_q  = i_cfg_data[62:0];
                    default: ;
                endcase
            end
            // retire before predicting, so a word landing on the same edge
            // is never matched against the command just taken
            if (i_m_tvalid && i_m_tready) begin
                if (expected_states.size() == 0) begin
                    n_fail++;
                    $display("%0t: result word with nothing outstanding, expected none, got %h",
                             $time, i_m_tdata);
                end else begin
                    compare_word(expected_states.pop_front(),
                                 {i_m_tdata[95:0], i_m_tdata[191:96], i_m_tdata[192]});
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_states.push_back(advance_particle(i_s_tuser, i_s_tdata));
            end
            o_pending <= expected_states.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the particle Euler integrator regression: clock, reset, stimulus
// and verdict. Depends on peu_pkg, the block and peu_checker.
module testbench;
    import peu_pkg::*;

    localparam int          N_DIRECTED  = 23;
    localparam int          N_RANDOM    = 400;
    localparam int          WORDS_PHASE = 40;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;   // 1.0 in Q16.16
    localparam logic [31:0] W_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN       = 32'h8000_0000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int n_fail;
    int n_pending;
    int n_sent     = 0;
    int n_cycles   = 0;
    bit tx_idle_en = 1'b1;   // sender may leave gaps
    bit rx_idle_en = 1'b1;   // receiver may stall

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    particle_euler_integrator_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    peu_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    // Receiver back-pressure: while enabled, tready is drawn low at random with a 31 percent chance.
    always @(posedge clk) begin
        m_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 31);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("particle_euler_integrator_top regression: fail");
            $finish;
        end
    end

    // Mix of full-scale corners, fully random patterns and small values that
    // keep the particle in range long enough for the steps to mean something.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 11))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        endcase
    endfunction

    // Offer one word and hold it until taken. tvalid stays high across
    // back-to-back words; it only drops when a gap is chosen.
    task automatic send_word(input logic [2:0] op, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        if (tx_idle_en && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 31);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // Stop offering and wait until every predicted word has been returned.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
    endtask

    // Registers are only touched with the block idle. Bits above each
    // register's width carry junk, which the block must ignore.
    task automatic set_config(input logic [1:0] mode, input logic [30:0] dt,
                              input logic [30:0] invm, input logic [62:0] thr);
        logic [62:0] junk;
        junk = 63'({$urandom, $urandom});
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= {junk[62:2], mode};
        @(posedge clk);
        cfg_idx  <= CFG_DT;
        cfg_data <= {junk[62:31], dt};
        @(posedge clk);
        cfg_idx  <= CFG_INVM;
        cfg_data <= {junk[62:31], invm};
        @(posedge clk);
        cfg_idx  <= CFG_THRESH;
        cfg_data <= thr;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [1:0]  mode;
        logic [30:0] dt;
        logic [30:0] invm;
        logic [62:0] thr;
        int          p;
        int          phase_start;
        bit          paused;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset register values first ----
        send_word(OP_STEP, '0, '0, '0);                   // step of a particle at rest
        send_word(3'd6, W_MAX, W_MIN, 32'hFFFF_FFFF);     // spare codes change nothing
        send_word(3'd7, W_MIN, W_MAX, 32'h5555_AAAA);
        send_word(OP_ADD_FORCE, W_MAX, W_MIN, 32'd1);
        send_word(OP_ADD_FORCE, W_MAX, W_MIN, 32'hFFFF_FFFF); // force sum saturates
        send_word(OP_FORCE_ACC, '0, '0, '0);              // static particle: zero acceleration
        send_word(OP_LOAD_POS, W_MIN, W_MAX, '0);
        send_word(OP_LOAD_VEL, W_MAX, W_MIN, 32'hFFFF_FFFF);
        send_word(OP_STEP, '0, '0, '0);                   // explicit step from the loaded full-scale state
        send_word(OP_CLR_FORCE, W_MAX, W_MAX, W_MAX);

        // semi-implicit, dt 1.0, heaviest inverse mass, zero threshold
        set_config(MODE_SEMI, 31'(Q_ONE), '1, '0);
        send_word(OP_ADD_FORCE, Q_ONE, -Q_ONE, 32'd3);
        send_word(OP_FORCE_ACC, '0, '0, '0);
        send_word(OP_LOAD_VEL, '0, '0, '0);
        send_word(OP_STEP, '0, '0, '0);
        send_word(OP_LOAD_VEL, '0, '0, 32'd1);            // smallest speed above zero

        // kinematic, odd full-scale dt so the half step truncates, top threshold
        set_config(MODE_KINEMAT, '1, 31'(Q_ONE), '1);
        send_word(OP_ADD_FORCE, -(Q_ONE << 1), Q_ONE, 32'h0000_8001);
        send_word(OP_FORCE_ACC, '0, '0, '0);
        send_word(OP_STEP, '0, '0, '0);
        send_word(OP_STEP, '0, '0, '0);

        // spare mode code steps as explicit; zero dt, tiny inverse mass
        set_config(2'd3, '0, 31'd3, 63'd4295);
        send_word(OP_FORCE_ACC, '0, '0, '0);
        send_word(OP_STEP, '0, '0, '0);
        send_word(OP_LOAD_POS, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001);
        send_word(OP_STEP, '0, '0, '0);

        // ---- random part: phases of well-formed frames and noise words under fresh settings ----
        for (p = 0; n_sent < N_DIRECTED + N_RANDOM; p++) begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       dt = '0;
                1:       dt = '1;
                2:       dt = 31'($urandom);
                default: dt = 31'($urandom_range(64, 32'h0002_0000));
            endcase
            case ($urandom_range(0, 4))
                0:       invm = '0;
                1:       invm = '1;
                2:       invm = 31'($urandom);
                default: invm = 31'($urandom_range(64, 32'h0004_0000));
            endcase
            case ($urandom_range(0, 4))
                0:       thr = '0;
                1:       thr = '1;
                2:       thr = 63'({$urandom, $urandom});
                default: thr = 63'({$urandom_range(0, 255), $urandom});
            endcase
            set_config(mode, dt, invm, thr);

            // phase 3 runs flat out on both sides
            tx_idle_en  = (p != 3);
            rx_idle_en <= (p != 3);
            phase_start = n_sent;
            paused      = 1'b0;

            while (n_sent < phase_start + WORDS_PHASE) begin
                // in even phases, let the block drain completely mid-phase before going on
                if (!paused && (p % 2 == 0) && n_sent >= phase_start + WORDS_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any code, any vector
                    repeat ($urandom_range(1, 3)) begin
                        send_word(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
                    end
                end else begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_word(OP_LOAD_POS, rand_comp(), rand_comp(), rand_comp());
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        send_word(OP_LOAD_VEL, rand_comp(), rand_comp(), rand_comp());
                    end
                    // now and then skip the clear so forces build up across frames
                    if ($urandom_range(0, 9) < 7) begin
                        send_word(OP_CLR_FORCE, $urandom, $urandom, $urandom);
                    end
                    repeat ($urandom_range(1, 3)) begin
                        send_word(OP_ADD_FORCE, rand_comp(), rand_comp(), rand_comp());
                    end
                    send_word(OP_FORCE_ACC, $urandom, $urandom, $urandom);
                    repeat ($urandom_range(1, 4)) begin
                        send_word(OP_STEP, $urandom, $urandom, $urandom);
                    end
                end
            end
        end

        // drain, then idle before the verdict so a stray word would be caught
        wait_drained();
        repeat (16) @(posedge clk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("particle_euler_integrator_top regression: pass");
        end else begin
            $display("particle_euler_integrator_top regression: fail");
        end
        $finish;
    end

endmodule
